// ===== src/fhv_pkg.sv =====
package fhv_pkg;

  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_OVERSIZE  = 3'd2;
  localparam logic [2:0] VERDICT_MAGIC     = 3'd3;
  localparam logic [2:0] VERDICT_COUNT0    = 3'd4;
  localparam logic [2:0] VERDICT_INDEX     = 3'd5;
  localparam logic [2:0] VERDICT_LAST      = 3'd6;
  localparam logic [2:0] VERDICT_STREAM    = 3'd7;

  localparam logic [1:0] CFG_MAGIC_VALUE       = 2'd0;
  localparam logic [1:0] CFG_MAX_LENGTH        = 2'd1;
  localparam logic [1:0] CFG_KEYFRAME_BIT      = 2'd2;
  localparam logic [1:0] CFG_LAST_FLAG_BIT     = 2'd3;

  typedef logic [HDR_BYTES-1:0][7:0] header_t;

  // one finished datagram handed from front to back
  typedef struct packed {
    logic [15:0] len;
    logic [2:0]  early_verdict;
    header_t     hdr;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== src/fragment_header_validator.sv =====
// Takes one byte beat per cycle while in_stall is low; no bubbles between datagrams.
// The verdict follows the final byte beat through front capture into a two-entry
// queue, then through the registered check stage.
// Input stalls only while the queue is full, which happens only when the output side stalls.
// Synchronous active-low reset clears byte count, queue and output valid;
// configuration resets to magic 0, max length 1400, keyframe bit 0, last bit 1.
module fragment_header_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_verdict,
  output logic        out_keyframe,
  output logic        out_last_flag,
  output logic        out_stream,
  output logic [31:0] out_seq_num,
  output logic [15:0] out_part_index,
  output logic [15:0] out_part_total,
  output logic [15:0] out_payload_length,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fhv_pkg::*;

  logic [7:0]    magic_r;
  logic [15:0]   max_len_r;
  logic [2:0]    key_bit_r;
  logic [2:0]    last_bit_r;

  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head_job;
  queue_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= 8'd0;
      max_len_r  <= 16'd1400;
      key_bit_r  <= 3'd0;
      last_bit_r <= 3'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAGIC_VALUE:       magic_r    <= cfg_data[7:0];
        CFG_MAX_LENGTH:        max_len_r  <= cfg_data;
        CFG_KEYFRAME_BIT:      key_bit_r  <= cfg_data[2:0];
        CFG_LAST_FLAG_BIT:     last_bit_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  fhv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .in_stall      (in_stall),
    .magic_value   (magic_r),
    .max_length    (max_len_r),
    .queue_full    (status.full),
    .push          (push),
    .push_job      (push_job)
  );

  fhv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (status)
  );

  fhv_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_job           (head_job),
    .status             (status),
    .pop                (pop),
    .keyframe_bit       (key_bit_r),
    .last_flag_bit      (last_bit_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (out_verdict),
    .out_keyframe       (out_keyframe),
    .out_last_flag      (out_last_flag),
    .out_stream         (out_stream),
    .out_seq_num        (out_seq_num),
    .out_part_index     (out_part_index),
    .out_part_total     (out_part_total),
    .out_payload_length (out_payload_length)
  );

endmodule

// ===== src/fhv_front.sv =====
module fhv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  input  logic                in_final_byte,
  output logic                in_stall,
  input  logic [7:0]          magic_value,
  input  logic [15:0]         max_length,
  input  logic                queue_full,
  output logic                push,
  output fhv_pkg::job_t       push_job
);
  import fhv_pkg::*;

  logic [15:0] count_r, count_nxt;
  header_t     hdr_r, hdr_nxt;
  logic [15:0] len;
  logic        accept;

  assign in_stall = queue_full;
  assign accept   = in_valid & ~in_stall;
  assign len      = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;

  always_comb begin
    hdr_nxt = hdr_r;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (count_r == 16'(i)) begin
        hdr_nxt[i] = in_data_byte;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = in_final_byte ? 16'd0 : len;
    end
  end

  always_comb begin
    push_job.len = len;
    push_job.hdr = hdr_nxt;
    if (len < 16'(HDR_BYTES)) begin
      push_job.early_verdict = VERDICT_SHORT;
    end else if (len > max_length) begin
      push_job.early_verdict = VERDICT_OVERSIZE;
    end else if (hdr_r[0] != magic_value) begin
      push_job.early_verdict = VERDICT_MAGIC;
    end else begin
      push_job.early_verdict = VERDICT_OK;
    end
  end

  assign push = accept & in_final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

// ===== src/fhv_queue.sv =====
module fhv_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fhv_pkg::job_t         push_job,
  input  logic                  pop,
  output fhv_pkg::job_t         head_job,
  output fhv_pkg::queue_status_t status
);
  import fhv_pkg::*;

  job_t        entry_r [QUEUE_DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  used_r, used_nxt;

  assign status.full  = (used_r == 2'(QUEUE_DEPTH));
  assign status.empty = (used_r == 2'd0);
  assign head_job     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    used_nxt   = used_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      used_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/fhv_back.sv =====
module fhv_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fhv_pkg::job_t         head_job,
  input  fhv_pkg::queue_status_t status,
  output logic                  pop,
  input  logic [2:0]            keyframe_bit,
  input  logic [2:0]            last_flag_bit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_verdict,
  output logic                  out_keyframe,
  output logic                  out_last_flag,
  output logic                  out_stream,
  output logic [31:0]           out_seq_num,
  output logic [15:0]           out_part_index,
  output logic [15:0]           out_part_total,
  output logic [15:0]           out_payload_length
);
  import fhv_pkg::*;

  logic        valid_r;
  logic [2:0]  verdict_r, verdict_nxt;
  logic        keyframe_r, last_r, stream_r;
  logic [31:0] seq_r;
  logic [15:0] idx_r, cnt_r, plen_r;

  logic [7:0]  flags;
  logic [15:0] stream, idx, cnt;
  logic [31:0] seq;
  logic        last, want_last, ok;

  assign pop = ~status.empty & (~valid_r | ~out_stall);

  always_comb begin
    flags     = head_job.hdr[1];
    stream    = {head_job.hdr[2], head_job.hdr[3]};
    seq       = {head_job.hdr[4], head_job.hdr[5], head_job.hdr[6], head_job.hdr[7]};
    idx       = {head_job.hdr[8], head_job.hdr[9]};
    cnt       = {head_job.hdr[10], head_job.hdr[11]};
    last      = flags[last_flag_bit];
    want_last = (idx == cnt - 16'd1);
    if (head_job.early_verdict != VERDICT_OK) begin
      verdict_nxt = head_job.early_verdict;
    end else if (cnt == 16'd0) begin
      verdict_nxt = VERDICT_COUNT0;
    end else if (idx >= cnt) begin
      verdict_nxt = VERDICT_INDEX;
    end else if (last != want_last) begin
      verdict_nxt = VERDICT_LAST;
    end else if (stream > 16'd1) begin
      verdict_nxt = VERDICT_STREAM;
    end else begin
      verdict_nxt = VERDICT_OK;
    end
    ok = (verdict_nxt == VERDICT_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r  <= verdict_nxt;
      keyframe_r <= ok & flags[keyframe_bit];
      last_r     <= ok & last;
      stream_r   <= ok & stream[0];
      seq_r      <= ok ? seq : 32'd0;
      idx_r      <= ok ? idx : 16'd0;
      cnt_r      <= ok ? cnt : 16'd0;
      plen_r     <= ok ? head_job.len - 16'(HDR_BYTES) : 16'd0;
    end
  end

  assign out_valid          = valid_r;
  assign out_verdict        = verdict_r;
  assign out_keyframe       = keyframe_r;
  assign out_last_flag      = last_r;
  assign out_stream         = stream_r;
  assign out_seq_num        = seq_r;
  assign out_part_index     = idx_r;
  assign out_part_total     = cnt_r;
  assign out_payload_length = plen_r;

endmodule
